@@ src/nmat_pkg.sv @@
// nmat_pkg: types and constants shared by the neighbor mean adaptive threshold block
// used by neighbor_mean_adaptive_threshold and its checker; no dependencies
package nmat_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;

  localparam int PixW     = 8;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = 13;
  localparam int WidthW   = 11;
  localparam int HeightW  = 13;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;
  localparam int LineW    = 2 * PixW;
  localparam int SumW     = PixW + 3;

  localparam logic [CfgIdxW-1:0] CfgImageWidth   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgBinarizeMode = CfgIdxW'(2);

  localparam logic [WidthW-1:0]  WidthRst  = WidthW'(640);
  localparam logic [HeightW-1:0] HeightRst = HeightW'(480);
  localparam logic [WidthW-1:0]  WidthMin  = WidthW'(2);
  localparam logic [WidthW-1:0]  WidthMax  = WidthW'(MaxWidth);
  localparam logic [HeightW-1:0] HeightMin = HeightW'(2);
  localparam logic [HeightW-1:0] HeightMax = HeightW'(MaxHeight);

  localparam logic [PixW-1:0] PixMax   = PixW'(255);
  localparam logic [SumW-1:0] RoundAdd = SumW'(4);

  localparam int FifoDepth = 3;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            is_pad;
  } in_t;

  typedef struct packed {
    logic [PixW-1:0] value;
    logic            frame_last;
  } out_t;

endpackage

@@ src/neighbor_mean_adaptive_threshold.sv @@
// Neighbor mean adaptive threshold: 3x3 neighbor mean filter and binarizer on a pixel stream.
// Holds two line stores in one read-modify-write memory; depends on nmat_pkg.
//
// Accepts one pixel per clock, when not stalled, in raster order and returns, for each frame
// pixel, the rounded mean of its eight neighbors (out-of-frame neighbors are zero), or 0/255
// against that mean in binarize mode. A result is queued after the transaction that completes
// its window, so a frame of W x H pixels needs W*H + W + 1 input transactions: the tail is fed
// as pad items. The pace of one pixel per cycle is set by the line store, a single memory of
// {upper, middle} rows read and written back once per pixel with a registered read.
// A three-entry output queue lets the input keep flowing while a result waits. Writing the
// width or height restarts the frame position; configure only while the block is idle.
module neighbor_mean_adaptive_threshold (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nmat_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nmat_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nmat_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nmat_pkg::out_t                out_data_o
);
  import nmat_pkg::*;

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic               mode_q;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic               cfg_restart;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            in_fire;
  logic            col_zero, r_ge1, r_ge2, emit0, last0, row_end;
  logic [PixW-1:0] pix0;

  logic            s1_valid_q;
  logic [PixW-1:0] s1_pix_q;
  logic            s1_col0_q, s1_rge1_q, s1_rge2_q, s1_emit_q, s1_last_q;
  logic [ColW-1:0] s1_addr_q;

  logic [LineW-1:0] line_mem [MaxWidth];
  logic [LineW-1:0] line_rd_q;
  logic             fwd_hit_q;
  logic [LineW-1:0] fwd_data_q;
  logic [LineW-1:0] line_raw, line_wr;
  logic [PixW-1:0]  up_raw, mid_raw, top_px, mid_px;

  logic [PixW-1:0] win_q [9];
  logic [PixW-1:0] win_d [9];
  logic [PixW-1:0] tap [9];
  logic [SumW-1:0] sum, rounded;
  logic [PixW-1:0] mean, res_value;

  out_t            fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  // configuration
  assign cfg_restart = cfg_we_i && (cfg_index_i == CfgImageWidth ||
                                    cfg_index_i == CfgImageHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgImageWidth:   width_q  <= cfg_data_i[WidthW-1:0];
        CfgImageHeight:  height_q <= cfg_data_i[HeightW-1:0];
        CfgBinarizeMode: mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < WidthMin) begin
      w_eff = WidthMin;
    end else if (width_q > WidthMax) begin
      w_eff = WidthMax;
    end else begin
      w_eff = width_q;
    end
    if (height_q < HeightMin) begin
      h_eff = HeightMin;
    end else if (height_q > HeightMax) begin
      h_eff = HeightMax;
    end else begin
      h_eff = height_q;
    end
  end

  // stage 0: position counters and line store read
  assign in_fire  = in_valid_i && !in_stall_o;
  assign col_zero = (col_q == '0);
  assign r_ge1    = (row_q != '0);
  assign r_ge2    = (row_q >= RowW'(2));
  assign emit0    = col_zero ? r_ge2 : r_ge1;
  assign last0    = col_zero && (row_q == RowW'(h_eff + HeightW'(1)));
  assign row_end  = ({1'b0, col_q} == WidthW'(w_eff - WidthW'(1)));
  assign pix0     = (!in_data_i.is_pad && (row_q < RowW'(h_eff))) ? in_data_i.pixel : '0;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (last0) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= in_fire;
      fwd_hit_q  <= in_fire && s1_valid_q && (col_q == s1_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= pix0;
      s1_col0_q <= col_zero;
      s1_rge1_q <= r_ge1;
      s1_rge2_q <= r_ge2;
      s1_emit_q <= emit0;
      s1_last_q <= last0;
      s1_addr_q <= col_q;
    end
    fwd_data_q <= line_wr;
  end

  // line store: {upper, middle} per column, read-first
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      line_rd_q <= line_mem[col_q];
    end
    if (s1_valid_q) begin
      line_mem[s1_addr_q] <= line_wr;
    end
  end

  // stage 1: window, filter and write-back
  assign line_raw = fwd_hit_q ? fwd_data_q : line_rd_q;
  assign up_raw   = line_raw[LineW-1:PixW];
  assign mid_raw  = line_raw[PixW-1:0];
  assign line_wr  = {mid_raw, s1_pix_q};
  assign top_px   = s1_rge2_q ? up_raw : '0;
  assign mid_px   = s1_rge1_q ? mid_raw : '0;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      tap[i] = win_q[i+3];
    end
    tap[6] = s1_col0_q ? '0 : top_px;
    tap[7] = s1_col0_q ? '0 : mid_px;
    tap[8] = s1_col0_q ? '0 : s1_pix_q;
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        sum = sum + SumW'(tap[i]);
      end
    end
  end

  assign rounded   = sum + RoundAdd;
  assign mean      = rounded[SumW-1:3];
  assign res_value = mode_q ? ((tap[4] < mean) ? '0 : PixMax) : mean;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_d[i] = win_q[i];
    end
    if (cfg_restart || (s1_valid_q && s1_last_q)) begin
      for (int i = 0; i < 9; i++) begin
        win_d[i] = '0;
      end
    end else if (s1_valid_q) begin
      for (int i = 0; i < 6; i++) begin
        win_d[i] = s1_col0_q ? '0 : win_q[i+3];
      end
      win_d[6] = top_px;
      win_d[7] = mid_px;
      win_d[8] = s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // output queue
  assign push        = s1_valid_q && s1_emit_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign in_stall_o  = (({1'b0, cnt_q} + (CntW+1)'(push)) >= (CntW+1)'(FifoDepth));

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].value      <= res_value;
      fifo_q[wr_ptr_q].frame_last <= s1_last_q;
    end
  end

endmodule

@@ src/nmat_checker.sv @@
// nmat_checker: port-level assertions for neighbor_mean_adaptive_threshold, bound to the top
// depends on nmat_pkg
module nmat_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [nmat_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [nmat_pkg::CfgDataW-1:0] cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input nmat_pkg::out_t                out_data_o
);
  import nmat_pkg::*;

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i && cfg_index_i == CfgBinarizeMode) begin
      mode_q <= cfg_data_i[0];
    end
  end

  // a result held by the sink stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // an unstalled output cycle always reopens the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> !in_stall_o)
    else $error("input stalled after an unstalled output cycle");

  // binarize mode only yields black or white
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q |-> out_data_o.value == '0 || out_data_o.value == PixMax)
    else $error("binarized value is neither 0 nor 255");

  // nothing comes out of an empty pipeline right after reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output transaction valid right after reset");

endmodule

bind neighbor_mean_adaptive_threshold nmat_checker u_nmat_checker (.*);
